// File: hdl/wwge_pkg.sv
// Package for the wireworld generation engine: sizes, cell state codes,
// command codes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none
package wwge_pkg;
    localparam int NumCells = 1024;
    localparam int NumLinks = 8;
    localparam int CellW = $clog2(NumCells);
    localparam int SlotW = $clog2(NumLinks);
    localparam int LinkAddrW = CellW + SlotW;
    localparam int LinkW = 11;
    localparam logic [31:0] GenLimitReset = 32'd1000;
    localparam logic [1:0] CountSat = 2'd3;

    typedef enum logic [1:0] {
        ST_UNUSED = 2'd0,
        ST_COPPER = 2'd1,
        ST_HEAD   = 2'd2,
        ST_TAIL   = 2'd3
    } cell_st_t;

    typedef enum logic [2:0] {
        CMD_WRITE_CELL = 3'd0,
        CMD_WRITE_LINK = 3'd1,
        CMD_STEP       = 3'd2,
        CMD_RUN        = 3'd3,
        CMD_READ_CELL  = 3'd4
    } cmd_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_WR_CELL,
        OP_WR_LINK,
        OP_RD_CELL,
        OP_CLR_CNT,
        OP_SCAN_CELL,
        OP_SCAN_LINK,
        OP_SCAN_TGT,
        OP_UPD_CELL,
        OP_UPD_WB
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [CellW-1:0] cell_idx;
        logic [SlotW-1:0] slot;
        logic            gen_start;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] rd_state;
        logic       is_head;
        logic       gen_active;
    } dp_sts_t;
endpackage
`default_nettype wire

// File: hdl/wwge_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on nothing.
`default_nettype none
interface wwge_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [9:0] cell_index;
    logic [2:0] neighbour_slot;
    logic [9:0] neighbour_index;
    logic       neighbour_valid;
    logic [1:0] new_state;
    modport source (output valid, command, cell_index, neighbour_slot, neighbour_index,
                    neighbour_valid, new_state, input ready);
    modport sink (input valid, command, cell_index, neighbour_slot, neighbour_index,
                  neighbour_valid, new_state, output ready);
endinterface

interface wwge_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cell_state;
    logic        still_active;
    logic [31:0] generations_done;
    modport source (output valid, cell_state, still_active, generations_done, input ready);
    modport sink (input valid, cell_state, still_active, generations_done, output ready);
endinterface
`default_nettype wire

// File: hdl/wwge_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module wwge_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hdl/wwge_datapath.sv
// Datapath: cell, link and head-count memories plus the active flag.
// Depends on wwge_pkg and wwge_ram.
`default_nettype none
module wwge_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wwge_pkg::dp_cmd_t  cmd,
    input  wire logic [1:0]         wr_state,
    input  wire logic [wwge_pkg::LinkW-1:0] wr_link,
    output wwge_pkg::dp_sts_t       sts
);
    import wwge_pkg::*;

    // Memory contents are made valid by a clear sweep after reset (controller).
    logic                 cs_we;
    logic [CellW-1:0]     cs_waddr, cs_raddr;
    logic [1:0]           cs_wdata, cs_rdata;
    logic                 lk_we;
    logic [LinkAddrW-1:0] lk_addr;
    logic [LinkW-1:0]     lk_wdata, lk_rdata;
    logic                 hc_we;
    logic [CellW-1:0]     hc_waddr, hc_raddr;
    logic [1:0]           hc_wdata, hc_rdata;
    logic                 active_reg, active_next;
    logic [CellW-1:0]     cur_reg, cur_next;
    logic [1:0]           st_reg, st_next;
    op_t                  op_d1_reg;

    wwge_ram #(.Width(2), .Depth(NumCells)) u_cells (
        .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
        .raddr(cs_raddr), .rdata(cs_rdata));
    wwge_ram #(.Width(LinkW), .Depth(NumCells * NumLinks)) u_links (
        .clk(clk), .we(lk_we), .waddr(lk_addr), .wdata(lk_wdata),
        .raddr(lk_addr), .rdata(lk_rdata));
    wwge_ram #(.Width(2), .Depth(NumCells)) u_counts (
        .clk(clk), .we(hc_we), .waddr(hc_waddr), .wdata(hc_wdata),
        .raddr(hc_raddr), .rdata(hc_rdata));

    // Scan of one link: link read -> target cell and count read -> count write.
    always_comb
    begin
        cs_we = 1'b0; cs_waddr = cmd.cell_idx; cs_wdata = wr_state; cs_raddr = cmd.cell_idx;
        lk_we = 1'b0; lk_addr = {cmd.cell_idx, cmd.slot}; lk_wdata = wr_link;
        hc_we = 1'b0; hc_waddr = cmd.cell_idx; hc_wdata = 2'd0; hc_raddr = cmd.cell_idx;
        active_next = active_reg;
        cur_next = cur_reg;
        st_next = st_reg;
        if (cmd.gen_start)
        begin
            active_next = 1'b0;
        end
        unique case (cmd.op)
            OP_INIT:
            begin
                cs_we = 1'b1; cs_wdata = ST_UNUSED;
                lk_we = 1'b1; lk_wdata = '0;
                hc_we = 1'b1;
            end
            OP_WR_CELL: cs_we = 1'b1;
            OP_WR_LINK: lk_we = 1'b1;
            OP_CLR_CNT: hc_we = 1'b1;
            OP_SCAN_TGT:
            begin
                cs_raddr = lk_rdata[CellW-1:0];
                hc_raddr = lk_rdata[CellW-1:0];
                cur_next = lk_rdata[CellW-1:0];
            end
            OP_UPD_CELL: cur_next = cmd.cell_idx;
            OP_UPD_WB:
            begin
                cs_waddr = cur_reg;
                unique case (cs_rdata)
                    ST_TAIL: begin cs_we = 1'b1; cs_wdata = ST_COPPER; end
                    ST_HEAD: begin cs_we = 1'b1; cs_wdata = ST_TAIL; end
                    ST_COPPER:
                    begin
                        if (hc_rdata == 2'd1 || hc_rdata == 2'd2)
                        begin
                            cs_we = 1'b1; cs_wdata = ST_HEAD; active_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (cmd.op == OP_SCAN_CELL && cs_rdata == ST_HEAD && op_d1_reg == OP_SCAN_CELL)
        begin
            active_next = 1'b1;
        end
        // Count update in the cycle after the target reads were issued.
        if (op_d1_reg == OP_SCAN_TGT && cs_rdata == ST_COPPER && hc_rdata != CountSat
            && st_reg[0])
        begin
            hc_we = 1'b1; hc_waddr = cur_reg; hc_wdata = hc_rdata + 2'd1;
        end
        if (op_d1_reg == OP_SCAN_LINK || cmd.op == OP_SCAN_TGT)
        begin
            st_next = {1'b0, lk_rdata[LinkW-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            op_d1_reg <= OP_NONE;
        end
        else
        begin
            active_reg <= active_next;
            op_d1_reg <= cmd.op;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        st_reg <= st_next;
    end

    assign sts.rd_state = cs_rdata;
    assign sts.is_head = (cs_rdata == ST_HEAD);
    assign sts.gen_active = active_reg;
endmodule
`default_nettype wire

// File: hdl/wwge_ctrl.sv
// Controller: accepts commands, sequences clear, scan and update sweeps.
// Depends on wwge_pkg and wwge_if.
`default_nettype none
module wwge_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] max_gen,
    wwge_cmd_if.sink         cin,
    wwge_res_if.source       rout,
    output wwge_pkg::dp_cmd_t dcmd,
    output logic [1:0]       wr_state,
    output logic [wwge_pkg::LinkW-1:0] wr_link,
    input  wire wwge_pkg::dp_sts_t sts
);
    import wwge_pkg::*;

    typedef enum logic [9:0] {
        S_INIT  = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_RDW   = 10'b0000000100,
        S_CLR   = 10'b0000001000,
        S_SCELL = 10'b0000010000,
        S_SCHK  = 10'b0000100000,
        S_SLINK = 10'b0001000000,
        S_UPD   = 10'b0010000000,
        S_GEND  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CellW-1:0] cell_reg, cell_next;
    logic [SlotW:0]   slot_reg, slot_next;
    logic [2:0]       cmd_reg, cmd_next;
    logic [CellW-1:0] ci_reg;
    logic [2:0]       sl_reg;
    logic [9:0]       ni_reg;
    logic             nv_reg;
    logic [1:0]       ns_reg;
    logic [31:0]      done_reg, done_next;
    logic [1:0]       rd_reg, rd_next;
    logic             phase_reg, phase_next;
    logic [31:0]      lim;
    logic             acc;

    assign lim = (max_gen == 32'd0) ? 32'd1 : max_gen;
    assign acc = cin.valid && cin.ready;
    assign cin.ready = (state_reg == S_IDLE);
    assign rout.valid = (state_reg == S_OUT);
    assign rout.cell_state = rd_reg;
    assign rout.still_active = sts.gen_active;
    assign rout.generations_done = done_reg;
    assign wr_state = ns_reg;
    assign wr_link = {nv_reg, ni_reg};

    // Scan pipeline: each link takes a link read step and a target read step;
    // the count write lands in the following cycle, before the next target read.
    always_comb
    begin
        state_next = state_reg;
        cell_next = cell_reg;
        slot_next = slot_reg;
        cmd_next = cmd_reg;
        done_next = done_reg;
        rd_next = rd_reg;
        phase_next = phase_reg;
        dcmd.op = OP_NONE;
        dcmd.cell_idx = cell_reg;
        dcmd.slot = slot_reg[SlotW-1:0];
        dcmd.gen_start = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                // Clears every link slot, and each cell and count on the way.
                dcmd.op = OP_INIT;
                slot_next = slot_reg + 1'b1;
                if (slot_reg == (SlotW + 1)'(NumLinks - 1))
                begin
                    slot_next = '0;
                    cell_next = cell_reg + 1'b1;
                    if (cell_reg == CellW'(NumCells - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    cmd_next = cin.command;
                    done_next = 32'd0;
                    rd_next = 2'd0;
                    cell_next = '0;
                    unique case (cin.command)
                        CMD_WRITE_CELL, CMD_WRITE_LINK, CMD_READ_CELL: state_next = S_RDW;
                        CMD_STEP, CMD_RUN: state_next = S_CLR;
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_RDW:
            begin
                dcmd.cell_idx = ci_reg;
                dcmd.slot = sl_reg;
                unique case (cmd_reg)
                    CMD_WRITE_CELL: dcmd.op = OP_WR_CELL;
                    CMD_WRITE_LINK: dcmd.op = OP_WR_LINK;
                    default: dcmd.op = OP_RD_CELL;
                endcase
                phase_next = ~phase_reg;
                if (cmd_reg != CMD_READ_CELL)
                begin
                    phase_next = 1'b0;
                    state_next = S_OUT;
                end
                else if (phase_reg)
                begin
                    rd_next = sts.rd_state;
                    phase_next = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_CLR:
            begin
                // A run stops here once the last generation was quiet or the limit is met.
                if (cell_reg == '0 && cmd_reg == CMD_RUN && done_reg != 32'd0
                    && (!sts.gen_active || done_reg >= lim))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    dcmd.op = OP_CLR_CNT;
                    dcmd.gen_start = (cell_reg == '0);
                    cell_next = cell_reg + 1'b1;
                    if (cell_reg == CellW'(NumCells - 1))
                    begin
                        state_next = S_SCELL;
                    end
                end
            end
            S_SCELL:
            begin
                dcmd.op = OP_SCAN_CELL;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                dcmd.op = OP_SCAN_CELL;
                slot_next = '0;
                phase_next = 1'b0;
                if (sts.is_head)
                begin
                    state_next = S_SLINK;
                end
                else if (cell_reg == CellW'(NumCells - 1))
                begin
                    cell_next = '0;
                    state_next = S_UPD;
                end
                else
                begin
                    cell_next = cell_reg + 1'b1;
                    state_next = S_SCELL;
                end
            end
            S_SLINK:
            begin
                // slot_reg steps 0..NumLinks-1 with a link read and a target read per link.
                if (!phase_reg)
                begin
                    dcmd.op = OP_SCAN_LINK;
                    phase_next = 1'b1;
                end
                else
                begin
                    dcmd.op = OP_SCAN_TGT;
                    phase_next = 1'b0;
                    slot_next = slot_reg + 1'b1;
                    if (slot_reg == (SlotW + 1)'(NumLinks - 1))
                    begin
                        state_next = S_GEND;
                        phase_next = 1'b1;
                    end
                end
            end
            S_GEND:
            begin
                // A spare state lets the last count write land.
                if (phase_reg)
                begin
                    phase_next = 1'b0;
                end
                else if (cell_reg == CellW'(NumCells - 1))
                begin
                    cell_next = '0;
                    state_next = S_UPD;
                end
                else
                begin
                    cell_next = cell_reg + 1'b1;
                    state_next = S_SCELL;
                end
            end
            S_UPD:
            begin
                if (!phase_reg)
                begin
                    dcmd.op = OP_UPD_CELL;
                    phase_next = 1'b1;
                end
                else
                begin
                    dcmd.op = OP_UPD_WB;
                    phase_next = 1'b0;
                    cell_next = cell_reg + 1'b1;
                    if (cell_reg == CellW'(NumCells - 1))
                    begin
                        done_next = done_reg + 32'd1;
                        state_next = S_OUT;
                        if (cmd_reg == CMD_RUN)
                        begin
                            state_next = S_CLR;
                            cell_next = '0;
                        end
                    end
                end
            end
            S_OUT:
            begin
                if (rout.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cell_reg <= '0;
            slot_reg <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cell_reg <= cell_next;
            slot_reg <= slot_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        done_reg <= done_next;
        rd_reg <= rd_next;
        if (acc)
        begin
            ci_reg <= cin.cell_index;
            sl_reg <= cin.neighbour_slot;
            ni_reg <= cin.neighbour_index;
            nv_reg <= cin.neighbour_valid;
            ns_reg <= cin.new_state;
        end
    end
endmodule
`default_nettype wire

// File: hdl/wireworld_generation_engine_unit.sv
// Top level of the wireworld generation engine: configuration register,
// controller and datapath. Depends on wwge_pkg, wwge_if, wwge_ctrl, wwge_datapath.
//
// Usage: one command transaction on cmd_ch yields exactly one result
// transaction on res_ch. A generation clears the head counts, scans every
// cell (a scan and a check step each, plus a link read and a target read
// per link slot and a spare state for each head cell) and updates every
// cell (a read and a write-back step each); with many heads the link scan
// dominates. A run repeats generations until one is quiet or max_generations
// is met. After reset the cell, link and head-count memories are cleared,
// every link slot in turn, while no command is taken.
// max_generations is written through cfg_we/cfg_wdata and resets to 1000.
// A stalled result holds the block; the next command waits for it.
`default_nettype none
module wireworld_generation_engine_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    wwge_cmd_if.sink         cmd_ch,
    wwge_res_if.source       res_ch
);
    import wwge_pkg::*;

    logic [31:0]       max_gen_reg;
    dp_cmd_t           dcmd;
    dp_sts_t           sts;
    logic [1:0]        wr_state;
    logic [LinkW-1:0]  wr_link;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_gen_reg <= GenLimitReset;
        end
        else if (cfg_we)
        begin
            max_gen_reg <= cfg_wdata;
        end
    end

    wwge_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .max_gen(max_gen_reg), .cin(cmd_ch), .rout(res_ch),
        .dcmd(dcmd), .wr_state(wr_state), .wr_link(wr_link), .sts(sts));

    wwge_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(dcmd), .wr_state(wr_state), .wr_link(wr_link),
        .sts(sts));
endmodule
`default_nettype wire

// File: sim/wwge_tb_if.sv
`timescale 1ns / 100ps
// Checker-side notes for the channel interfaces of the wireworld engine bench.
// The bench uses wwge_cmd_if and wwge_res_if from hdl/wwge_if.sv and wwge_pkg.
package wwge_tb_pkg;
    import wwge_pkg::*;

    // One row of stimulus; expectation fields count only when check_it is set.
    typedef struct {
        logic [2:0]  command;
        logic [9:0]  cell_index;
        logic [2:0]  neighbour_slot;
        logic [9:0]  neighbour_index;
        logic        neighbour_valid;
        logic [1:0]  new_state;
        bit          check_it;
        logic [1:0]  want_state;
        logic        want_active;
        logic [31:0] want_gens;
    } wire_cmd_t;

    typedef struct {
        logic [1:0]  cell_state;
        logic        still_active;
        logic [31:0] generations_done;
    } wire_res_t;
endpackage

// File: sim/wireworld_generation_engine_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for wireworld_generation_engine_unit: directed table, then
// random commands checked against an in-bench wireworld predictor.
// Depends on wwge_pkg, wwge_if, wwge_tb_pkg and the RTL of the engine.
module wireworld_generation_engine_unit_tb;
    import wwge_pkg::*;
    import wwge_tb_pkg::*;

    localparam int StallLimit = 200000;
    localparam int MaxRunGens = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;

    wwge_cmd_if cmd_ch ();
    wwge_res_if res_ch ();

    wireworld_generation_engine_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_we (cfg_we),
        .cfg_wdata(cfg_wdata),
        .cmd_ch (cmd_ch),
        .res_ch (res_ch)
    );

    always #5 clk = ~clk;

    // Predicted engine state.
    cell_st_t    grid [NumCells];
    logic        link_on [NumCells*NumLinks];
    logic [9:0]  link_to [NumCells*NumLinks];
    logic        busy_flag;
    logic [31:0] gen_limit;

    wire_res_t   pending_results [$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          hold_request = 0;
    bit          no_gaps = 0;

    function automatic logic advance_generation();
        logic [1:0] heads [NumCells];
        logic       act;
        int         t;
        act = 1'b0;
        foreach (heads[i]) heads[i] = '0;
        for (int i = 0; i < NumCells; i++)
        begin
            if (grid[i] == ST_HEAD)
            begin
                act = 1'b1;
                for (int s = 0; s < NumLinks; s++)
                begin
                    t = link_to[i*NumLinks+s];
                    if (link_on[i*NumLinks+s] && grid[t] == ST_COPPER && heads[t] < CountSat)
                        heads[t]++;
                end
            end
        end
        for (int i = 0; i < NumCells; i++)
        begin
            case (grid[i])
                ST_TAIL: grid[i] = ST_COPPER;
                ST_HEAD: grid[i] = ST_TAIL;
                ST_COPPER:
                begin
                    if (heads[i] == 2'd1 || heads[i] == 2'd2)
                    begin
                        grid[i] = ST_HEAD;
                        act = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        busy_flag = act;
        return act;
    endfunction

    function automatic wire_res_t apply_command(wire_cmd_t c);
        wire_res_t   r;
        logic [31:0] lim;
        logic        go;
        r = '{2'd0, 1'b0, 32'd0};
        case (c.command)
            CMD_WRITE_CELL: grid[c.cell_index] = cell_st_t'(c.new_state);
            CMD_WRITE_LINK:
            begin
                link_on[{c.cell_index, c.neighbour_slot}] = c.neighbour_valid;
                link_to[{c.cell_index, c.neighbour_slot}] = c.neighbour_index;
            end
            CMD_STEP:
            begin
                void'(advance_generation());
                r.generations_done = 1;
            end
            CMD_RUN:
            begin
                lim = (gen_limit == 0) ? 32'd1 : gen_limit;
                do
                begin
                    go = advance_generation();
                    r.generations_done++;
                end while (go && r.generations_done < lim);
            end
            CMD_READ_CELL: r.cell_state = grid[c.cell_index];
            default: ;
        endcase
        r.still_active = busy_flag;
        return r;
    endfunction

    // Length a run would have, probed on a copy; capped just above MaxRunGens.
    function automatic int run_length();
        cell_st_t saved [NumCells];
        logic     saved_flag;
        int       n;
        logic     go;
        saved = grid;
        saved_flag = busy_flag;
        n = 0;
        do
        begin
            go = advance_generation();
            n++;
        end while (go && n < ((gen_limit == 0) ? 1 : gen_limit) && n <= MaxRunGens);
        grid = saved;
        busy_flag = saved_flag;
        return n;
    endfunction

    function automatic wire_cmd_t random_command();
        wire_cmd_t c;
        int        pick;
        pick = $urandom_range(0, 99);
        c.cell_index = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, 15)) : 10'($urandom);
        c.neighbour_index = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, 15))
                                                        : 10'($urandom);
        c.neighbour_slot = 3'($urandom);
        c.neighbour_valid = ($urandom_range(0, 3) != 0);
        c.new_state = ($urandom_range(0, 2) == 0) ? 2'($urandom) : ST_COPPER;
        if ($urandom_range(0, 5) == 0)
            c.new_state = ST_HEAD;
        c.check_it = 0;
        c.want_state = '0;
        c.want_active = 0;
        c.want_gens = '0;
        if (pick < 35)
            c.command = CMD_WRITE_CELL;
        else if (pick < 65)
            c.command = CMD_WRITE_LINK;
        else if (pick < 77)
            c.command = CMD_READ_CELL;
        else if (pick < 88)
            c.command = CMD_STEP;
        else if (pick < 96)
            c.command = CMD_RUN;
        else
            c.command = 3'($urandom_range(5, 7));
        // A run that would not settle soon is replaced by a single step.
        if (c.command == CMD_RUN && run_length() > MaxRunGens)
            c.command = CMD_STEP;
        return c;
    endfunction

    task automatic send_command(wire_cmd_t c);
        wire_res_t r;
        int        gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        r = apply_command(c);
        if (c.check_it)
            r = '{c.want_state, c.want_active, c.want_gens};
        pending_results.push_back(r);
        cmd_ch.command = c.command;
        cmd_ch.cell_index = c.cell_index;
        cmd_ch.neighbour_slot = c.neighbour_slot;
        cmd_ch.neighbour_index = c.neighbour_index;
        cmd_ch.neighbour_valid = c.neighbour_valid;
        cmd_ch.new_state = c.new_state;
        cmd_ch.valid = 1'b1;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_gen_limit(logic [31:0] value);
        cmd_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        gen_limit = value;
    endtask

    // Receiver: random stalls per transaction, plus one long hold on request.
    initial
    begin
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                res_ch.ready = 1'b0;
                repeat (3000) @(negedge clk);
                hold_request = 0;
            end
            else if (!no_gaps && $urandom_range(0, 12) != 0)
            begin
                res_ch.ready = 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        wire_res_t w;
        if ((res_ch.valid && res_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                errors++;
            end
            else
            begin
                w = pending_results.pop_front();
                if (res_ch.cell_state !== w.cell_state)
                begin
                    $error("cell_state: expected %0d, got %0d", w.cell_state, res_ch.cell_state);
                    errors++;
                end
                if (res_ch.still_active !== w.still_active)
                begin
                    $error("still_active: expected %0d, got %0d",
                           w.still_active, res_ch.still_active);
                    errors++;
                end
                if (res_ch.generations_done !== w.generations_done)
                begin
                    $error("generations_done: expected %0d, got %0d",
                           w.generations_done, res_ch.generations_done);
                    errors++;
                end
            end
        end
        if (idle_cycles >= StallLimit)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    wire_cmd_t directed [22];
    logic [31:0] limits [5] = '{32'd0, 32'd5, 32'hFFFF_FFFF, 32'd1, 32'd3};

    initial
    begin
        // Directed rows: reads of untouched cells, a short wire, a copper cell
        // excited by three heads (count saturates, no head), an invalid link,
        // a run that goes quiet, and unknown commands.
        directed = '{
            '{CMD_READ_CELL,  10'd0,    3'd0, 10'd0,    1'b0, 2'd0, 1, 2'd0, 1'b0, 32'd0},
            '{CMD_READ_CELL,  10'd1023, 3'd0, 10'd0,    1'b0, 2'd0, 1, 2'd0, 1'b0, 32'd0},
            '{CMD_WRITE_CELL, 10'd1023, 3'd0, 10'd0,    1'b0, ST_TAIL, 1, 2'd0, 1'b0, 32'd0},
            '{CMD_READ_CELL,  10'd1023, 3'd0, 10'd0,    1'b0, 2'd0, 1, ST_TAIL, 1'b0, 32'd0},
            '{CMD_WRITE_CELL, 10'd0,    3'd0, 10'd0,    1'b0, ST_COPPER, 0, 0, 0, 0},
            '{CMD_WRITE_CELL, 10'd1,    3'd0, 10'd0,    1'b0, ST_HEAD, 0, 0, 0, 0},
            '{CMD_WRITE_CELL, 10'd3,    3'd0, 10'd0,    1'b0, ST_COPPER, 0, 0, 0, 0},
            '{CMD_WRITE_CELL, 10'd4,    3'd0, 10'd0,    1'b0, ST_HEAD, 0, 0, 0, 0},
            '{CMD_WRITE_CELL, 10'd5,    3'd0, 10'd0,    1'b0, ST_HEAD, 0, 0, 0, 0},
            '{CMD_WRITE_CELL, 10'd6,    3'd0, 10'd0,    1'b0, ST_HEAD, 0, 0, 0, 0},
            '{CMD_WRITE_LINK, 10'd1,    3'd0, 10'd0,    1'b1, 2'd0, 0, 0, 0, 0},
            '{CMD_WRITE_LINK, 10'd1,    3'd7, 10'd1023, 1'b1, 2'd0, 0, 0, 0, 0},
            '{CMD_WRITE_LINK, 10'd2,    3'd3, 10'd0,    1'b0, 2'd0, 0, 0, 0, 0},
            '{CMD_WRITE_LINK, 10'd4,    3'd1, 10'd3,    1'b1, 2'd0, 0, 0, 0, 0},
            '{CMD_WRITE_LINK, 10'd5,    3'd2, 10'd3,    1'b1, 2'd0, 0, 0, 0, 0},
            '{CMD_WRITE_LINK, 10'd6,    3'd4, 10'd3,    1'b1, 2'd0, 0, 0, 0, 0},
            '{CMD_STEP,       10'd0,    3'd0, 10'd0,    1'b0, 2'd0, 0, 0, 0, 0},
            '{CMD_READ_CELL,  10'd0,    3'd0, 10'd0,    1'b0, 2'd0, 0, 0, 0, 0},
            '{CMD_RUN,        10'd0,    3'd0, 10'd0,    1'b0, 2'd0, 0, 0, 0, 0},
            '{3'd5,           10'd1023, 3'd7, 10'd1023, 1'b1, 2'd3, 0, 0, 0, 0},
            '{3'd7,           10'd0,    3'd0, 10'd0,    1'b0, 2'd0, 0, 0, 0, 0},
            '{CMD_READ_CELL,  10'd3,    3'd0, 10'd0,    1'b0, 2'd0, 0, 0, 0, 0}
        };
        foreach (grid[i]) grid[i] = ST_UNUSED;
        foreach (link_on[i])
        begin
            link_on[i] = 1'b0;
            link_to[i] = '0;
        end
        busy_flag = 1'b0;
        gen_limit = GenLimitReset;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = '0;
        cmd_ch.cell_index = '0;
        cmd_ch.neighbour_slot = '0;
        cmd_ch.neighbour_index = '0;
        cmd_ch.neighbour_valid = 1'b0;
        cmd_ch.new_state = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_command(directed[i]);

        foreach (limits[p])
        begin
            set_gen_limit(limits[p]);
            no_gaps = (p == 3);
            if (p == 1)
                hold_request = 1;
            repeat (20)
                send_command(random_command());
        end

        cmd_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
